// ===== sv/dcts_pkg.sv =====
// Shared constants, register codes and the table control struct for dense column selection.
`default_nettype none

package dcts_pkg;

  localparam int COUNT_W        = 20;
  localparam int COL_IDX_W      = 20;
  localparam int CAP_W          = 6;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 20;
  localparam int IN_TDATA_W     = 24;
  localparam int OUT_TDATA_W    = 24;
  localparam int MAX_DENSE_DEF  = 32;
  localparam int INDEX_BITS_DEF = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEL   = 1'b1;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ===== sv/dcts_kept_mem.sv =====
// Kept table memory: column index and count per entry, one write and one registered read port.
`default_nettype none

module dcts_kept_mem
  import dcts_pkg::*;
#(
  parameter int DEPTH = MAX_DENSE_DEF,
  parameter int AW    = 5,
  parameter int IW    = INDEX_BITS_DEF
) (
  input  wire logic               clk,
  input  wire mem_ctl_t           ctl,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [IW-1:0]      wr_idx,
  input  wire logic [COUNT_W-1:0] wr_cnt,
  input  wire logic [AW-1:0]      raddr,
  output logic [IW-1:0]           rd_idx,
  output logic [COUNT_W-1:0]      rd_cnt
);

  logic [IW-1:0]      idx_mem [DEPTH];
  logic [COUNT_W-1:0] cnt_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      idx_mem[waddr] <= wr_idx;
      cnt_mem[waddr] <= wr_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_idx <= idx_mem[raddr];
      rd_cnt <= cnt_mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/dcts_ctrl.sv =====
// Sequencer: sorted insertion into the kept table and ascending column-index emission of kept indices.
`default_nettype none

module dcts_ctrl
  import dcts_pkg::*;
#(
  parameter int MAX_DENSE  = MAX_DENSE_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF,
  parameter int AW         = 5,
  parameter int CW         = 6
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [COUNT_W-1:0]     thr,
  input  wire logic [CAP_W-1:0]       cap,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [COUNT_W-1:0]     in_count,
  input  wire logic                   in_eligible,
  input  wire logic                   in_last,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [COL_IDX_W-1:0]        out_index,
  output logic                        out_none,
  output logic                        out_last,
  output mem_ctl_t                    mem_ctl,
  output logic [AW-1:0]               mem_waddr,
  output logic [INDEX_BITS-1:0]       mem_wr_idx,
  output logic [COUNT_W-1:0]          mem_wr_cnt,
  output logic [AW-1:0]               mem_raddr,
  input  wire logic [INDEX_BITS-1:0]  mem_rd_idx,
  input  wire logic [COUNT_W-1:0]     mem_rd_cnt
);

  localparam int XW = (CW > CAP_W) ? CW : CAP_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CMP   = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_SCAN0 = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_PUT   = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [CW-1:0]         total_r, total_nxt;
  logic [INDEX_BITS-1:0] col_r, col_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [INDEX_BITS-1:0] idx_r, idx_nxt;
  logic                  last_r, last_nxt;
  logic [CW-1:0]         j_r, j_nxt;
  logic [AW-1:0]         k_r, k_nxt;
  logic [CW-1:0]         e_r, e_nxt;
  logic [INDEX_BITS-1:0] best_idx_r, best_idx_nxt;
  logic [AW-1:0]         best_pos_r, best_pos_nxt;
  logic                  best_found_r, best_found_nxt;
  logic [INDEX_BITS-1:0] prev_idx_r, prev_idx_nxt;
  logic [AW-1:0]         prev_pos_r, prev_pos_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [COL_IDX_W-1:0]  out_index_r, out_index_nxt;
  logic                  out_none_r, out_none_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [CW-1:0] cap_lim;
  logic [CW-1:0] n_clamp;
  logic [CW-1:0] total_inc;
  logic          accept;
  logic          candidate;
  logic          key_after;
  logic          take;
  logic          put_last;

  assign cap_lim   = (XW'(cap) < XW'(MAX_DENSE)) ? CW'(cap) : CW'(MAX_DENSE);
  assign n_clamp   = (total_r > cap_lim) ? cap_lim : total_r;
  assign total_inc = (total_r < cap_lim) ? total_r + CW'(1) : total_r;
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign candidate = in_eligible && (in_count > thr) && (cap_lim != '0);
  assign key_after = (e_r == '0) || (mem_rd_idx > prev_idx_r)
                     || ((mem_rd_idx == prev_idx_r) && (k_r > prev_pos_r));
  assign take      = key_after && (!best_found_r || (mem_rd_idx < best_idx_r));
  assign put_last  = (total_r == '0) || (e_r + CW'(1) == total_r);

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    col_nxt        = col_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    j_nxt          = j_r;
    k_nxt          = k_r;
    e_nxt          = e_r;
    best_idx_nxt   = best_idx_r;
    best_pos_nxt   = best_pos_r;
    best_found_nxt = best_found_r;
    prev_idx_nxt   = prev_idx_r;
    prev_pos_nxt   = prev_pos_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_index_nxt  = out_index_r;
    out_none_nxt   = out_none_r;
    out_last_nxt   = out_last_r;
    mem_ctl        = '0;
    mem_waddr      = AW'(j_r);
    mem_wr_idx     = idx_r;
    mem_wr_cnt     = cnt_r;
    mem_raddr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        mem_raddr = AW'(n_clamp - CW'(1));
        if (accept) begin
          cnt_nxt   = in_count;
          idx_nxt   = col_r;
          last_nxt  = in_last;
          col_nxt   = in_last ? '0 : col_r + INDEX_BITS'(1);
          total_nxt = n_clamp;
          j_nxt     = n_clamp;
          e_nxt     = '0;
          if (candidate) begin
            if (n_clamp == '0) begin
              state_nxt = ST_INS;
            end else begin
              mem_ctl.rd_en = 1'b1;
              state_nxt     = ST_CMP;
            end
          end else if (in_last) begin
            state_nxt = (n_clamp == '0) ? ST_PUT : ST_SCAN0;
          end
        end
      end
      ST_CMP: begin
        if (mem_rd_cnt < cnt_r) begin
          mem_ctl.wr_en = (j_r < cap_lim);
          mem_wr_idx    = mem_rd_idx;
          mem_wr_cnt    = mem_rd_cnt;
          j_nxt         = j_r - CW'(1);
          if (j_r == CW'(1)) begin
            state_nxt = ST_INS;
          end else begin
            mem_raddr     = AW'(j_r - CW'(1) - CW'(1));
            mem_ctl.rd_en = 1'b1;
          end
        end else begin
          mem_ctl.wr_en = (j_r < cap_lim);
          total_nxt     = total_inc;
          state_nxt     = last_r ? ST_SCAN0 : ST_IDLE;
        end
      end
      ST_INS: begin
        mem_ctl.wr_en = (j_r < cap_lim);
        total_nxt     = total_inc;
        state_nxt     = last_r ? ST_SCAN0 : ST_IDLE;
      end
      ST_SCAN0: begin
        mem_raddr      = '0;
        mem_ctl.rd_en  = 1'b1;
        k_nxt          = '0;
        best_found_nxt = 1'b0;
        state_nxt      = ST_SCAN;
      end
      ST_SCAN: begin
        if (take) begin
          best_idx_nxt   = mem_rd_idx;
          best_pos_nxt   = k_r;
          best_found_nxt = 1'b1;
        end
        if (k_r == AW'(total_r - CW'(1))) begin
          state_nxt = ST_PUT;
        end else begin
          mem_raddr     = k_r + AW'(1);
          mem_ctl.rd_en = 1'b1;
          k_nxt         = k_r + AW'(1);
        end
      end
      ST_PUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_index_nxt  = (total_r == '0) ? '0 : COL_IDX_W'(best_idx_r);
          out_none_nxt   = (total_r == '0);
          out_last_nxt   = put_last;
          prev_idx_nxt   = best_idx_r;
          prev_pos_nxt   = best_pos_r;
          e_nxt          = e_r + CW'(1);
          if (put_last) begin
            total_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      total_r      <= '0;
      col_r        <= '0;
      e_r          <= '0;
      best_found_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      col_r        <= col_nxt;
      e_r          <= e_nxt;
      best_found_r <= best_found_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    idx_r       <= idx_nxt;
    last_r      <= last_nxt;
    j_r         <= j_nxt;
    k_r         <= k_nxt;
    best_idx_r  <= best_idx_nxt;
    best_pos_r  <= best_pos_nxt;
    prev_idx_r  <= prev_idx_nxt;
    prev_pos_r  <= prev_pos_nxt;
    out_index_r <= out_index_nxt;
    out_none_r  <= out_none_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_index  = out_index_r;
  assign out_none   = out_none_r;
  assign out_last   = out_last_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CW'(MAX_DENSE))
    else $error("kept total above table depth");

  a_write_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.wr_en |-> (j_r < cap_lim))
    else $error("table write beyond cap");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_none) |-> (out_last && (out_index == '0)))
    else $error("empty result not a lone final beat");

  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> !in_tready)
    else $error("final column did not start emission");

  a_put_found: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_PUT) && (total_r != '0)) |-> best_found_r)
    else $error("selection pass found no entry");

endmodule

`default_nettype wire

// ===== sv/dense_column_top_k_select.sv =====
// Top level: configuration registers, kept table and selection sequencer.
//
//  channel | beat when                 | contents
//  --------+---------------------------+-----------------------------------------------
//  in_     | in_tvalid & in_tready     | tdata: nonzero_count; tuser: eligible; tlast
//  out_    | out_tvalid & out_tready   | tdata: column_index; tuser: none_selected; tlast
//  cfg_    | cfg_wr_en                 | index 0 dense_threshold, 1 max_selected
//
// A column that is not a candidate needs no table access; a candidate walks the table from
// its tail through the single read port, moving each entry of smaller count down a place.
// The final column adds one selection pass over the n kept entries per emitted index,
// or a none beat when empty. Synchronous active-low reset; no table clearing pass.
// in_tready is low while a column or emission is in progress; a full output register
// stalls emission but an idle block takes the next column with the last beat pending.
`default_nettype none

module dense_column_top_k_select
  import dcts_pkg::*;
#(
  parameter int MAX_DENSE  = MAX_DENSE_DEF,
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [19:0] nonzero_count
  input  wire logic                   in_tuser,   // [0] eligible
  input  wire logic                   in_tlast,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [19:0] column_index
  output logic                        out_tuser,  // [0] none_selected
  output logic                        out_tlast,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int AW = (MAX_DENSE > 1) ? $clog2(MAX_DENSE) : 1;
  localparam int CW = $clog2(MAX_DENSE + 1);

  logic [COUNT_W-1:0]    thr_r;
  logic [CAP_W-1:0]      cap_r;
  mem_ctl_t              mem_ctl;
  logic [AW-1:0]         mem_waddr;
  logic [INDEX_BITS-1:0] mem_wr_idx;
  logic [COUNT_W-1:0]    mem_wr_cnt;
  logic [AW-1:0]         mem_raddr;
  logic [INDEX_BITS-1:0] mem_rd_idx;
  logic [COUNT_W-1:0]    mem_rd_cnt;
  logic [COL_IDX_W-1:0]  out_index;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      cap_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r <= COUNT_W'(cfg_wdata);
        CFG_MAX_SEL:   cap_r <= cfg_wdata[CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dcts_kept_mem #(
    .DEPTH (MAX_DENSE),
    .AW    (AW),
    .IW    (INDEX_BITS)
  ) u_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .waddr  (mem_waddr),
    .wr_idx (mem_wr_idx),
    .wr_cnt (mem_wr_cnt),
    .raddr  (mem_raddr),
    .rd_idx (mem_rd_idx),
    .rd_cnt (mem_rd_cnt)
  );

  dcts_ctrl #(
    .MAX_DENSE  (MAX_DENSE),
    .INDEX_BITS (INDEX_BITS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .thr         (thr_r),
    .cap         (cap_r),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_count    (in_tdata[COUNT_W-1:0]),
    .in_eligible (in_tuser),
    .in_last     (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_index   (out_index),
    .out_none    (out_tuser),
    .out_last    (out_tlast),
    .mem_ctl     (mem_ctl),
    .mem_waddr   (mem_waddr),
    .mem_wr_idx  (mem_wr_idx),
    .mem_wr_cnt  (mem_wr_cnt),
    .mem_raddr   (mem_raddr),
    .mem_rd_idx  (mem_rd_idx),
    .mem_rd_cnt  (mem_rd_cnt)
  );

  assign out_tdata = {{(OUT_TDATA_W - COL_IDX_W){1'b0}}, out_index};

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for dense_column_top_k_select: streams column matrices and checks the selected columns.
`timescale 1ns / 100ps

module tb_top;
  import dcts_pkg::*;

  localparam int TBL_DEPTH   = MAX_DENSE_DEF;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYC  = 60;
  localparam int PHASE_ITEMS = 24;

  typedef struct packed {
    logic [COUNT_W-1:0] cnt;
    logic               elig;
    logic               last;
  } column_t;

  typedef struct packed {
    logic [COL_IDX_W-1:0] col;
    logic                 none;
    logic                 last;
  } pick_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;   // [19:0] nonzero_count
  logic                  in_tuser = 1'b0; // [0] eligible
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // [19:0] column_index
  logic                  out_tuser;       // [0] none_selected
  logic                  out_tlast;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  dense_column_top_k_select dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  column_t pending_columns[$];
  pick_t   expected_picks[$];
  int      errors = 0;
  int      cycles = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req = 1'b0;

  // selection state mirrored from the block
  logic [COL_IDX_W-1:0] kept_col [TBL_DEPTH];
  logic [COUNT_W-1:0]   kept_cnt [TBL_DEPTH];
  int unsigned          kept_n = 0;
  logic [COL_IDX_W-1:0] next_col = '0;
  logic [COUNT_W-1:0]   thr_val = '0;
  logic [CAP_W-1:0]     cap_val = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic void rank_column(logic [COUNT_W-1:0] cnt, logic elig, logic last);
    int unsigned          cap;
    int unsigned          pos;
    int unsigned          top;
    int                   j;
    logic [COL_IDX_W-1:0] order [TBL_DEPTH];
    logic [COL_IDX_W-1:0] v;
    pick_t                p;
    cap = (cap_val < TBL_DEPTH) ? cap_val : TBL_DEPTH;
    if (kept_n > cap) kept_n = cap;
    if (elig && cnt > thr_val && cap != 0) begin
      pos = 0;
      while (pos < kept_n && kept_cnt[pos] >= cnt) pos++;
      if (kept_n < cap || pos < kept_n) begin
        top = (kept_n < cap) ? kept_n : kept_n - 1;
        for (int i = top; i > pos; i--) begin
          kept_col[i] = kept_col[i-1];
          kept_cnt[i] = kept_cnt[i-1];
        end
        kept_col[pos] = next_col;
        kept_cnt[pos] = cnt;
        if (kept_n < cap) kept_n++;
      end
    end
    next_col = next_col + 1'b1;
    if (!last) return;
    if (kept_n == 0) begin
      p.col = '0;
      p.none = 1'b1;
      p.last = 1'b1;
      expected_picks.insert(expected_picks.size(), p);
    end else begin
      for (int i = 0; i < kept_n; i++) begin
        v = kept_col[i];
        j = i;
        while (j > 0 && order[j-1] > v) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      for (int i = 0; i < kept_n; i++) begin
        p.col = order[i];
        p.none = 1'b0;
        p.last = (i == kept_n - 1);
        expected_picks.insert(expected_picks.size(), p);
      end
    end
    kept_n = 0;
    next_col = '0;
  endfunction

  always @(posedge clk) begin : driver
    column_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        rank_column(in_tdata[COUNT_W-1:0], in_tuser, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (pending_columns.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          c = pending_columns.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(c.cnt);
          in_tuser  <= c.elig;
          in_tlast  <= c.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    int hold_left;
    bit hold_done;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : monitor
    pick_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_picks.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual tdata=%h tuser=%b tlast=%b",
                 $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = expected_picks.pop_front();
        if (out_tdata !== OUT_TDATA_W'(want.col) || out_tuser !== want.none ||
            out_tlast !== want.last) begin
          errors++;
          $display("%0t: mismatch, expected %h/%b/%b actual %h/%b/%b",
                   $time, OUT_TDATA_W'(want.col), want.none, want.last,
                   out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("dense_column_top_k_select verification failed");
      $finish;
    end
  end

  task automatic settle();
    while (pending_columns.size() != 0 || in_tvalid || expected_picks.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_DATA_W'(value);
    if (idx == CFG_THRESHOLD) thr_val = COUNT_W'(value);
    else cap_val = CAP_W'(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_col(int unsigned cnt, bit elig, bit last);
    column_t c;
    c.cnt = COUNT_W'(cnt);
    c.elig = elig;
    c.last = last;
    pending_columns.insert(pending_columns.size(), c);
  endtask

  function automatic int unsigned pick_count();
    int unsigned r;
    case ($urandom_range(4))
      0: r = $urandom & 32'hFFFFF;
      1: r = $urandom_range(0, 64);
      2: r = thr_val + $urandom_range(0, 4) - 2;
      3: r = $urandom_range(0, 1) ? 32'hFFFFF : 0;
      default: r = thr_val + $urandom_range(1, 200);
    endcase
    return r & 32'hFFFFF;
  endfunction

  task automatic pick_threshold();
    case ($urandom_range(3))
      0: write_reg(CFG_THRESHOLD, 0);
      1: write_reg(CFG_THRESHOLD, $urandom_range(0, 64));
      2: write_reg(CFG_THRESHOLD, $urandom & 32'hFFFFF);
      default: write_reg(CFG_THRESHOLD, 32'hFFFFF);
    endcase
  endtask

  task automatic pick_cap();
    int unsigned caps [12] = '{0, 1, 2, 3, 4, 7, 8, 16, 31, 32, 33, 63};
    write_reg(CFG_MAX_SEL, caps[$urandom_range(11)]);
  endtask

  // one matrix; sometimes the cap is lowered partway through
  task automatic feed_matrix(int len, bit elig_all);
    int cut;
    cut = (len >= 4 && $urandom_range(3) == 0) ? $urandom_range(1, len - 1) : 0;
    for (int i = 0; i < len; i++) begin
      if (cut != 0 && i == cut) begin
        settle();
        write_reg(CFG_MAX_SEL, $urandom_range(0, cap_val));
      end
      push_col(pick_count(), elig_all || ($urandom_range(99) < 85), i == len - 1);
    end
  endtask

  initial begin : stimulus
    int fed;
    int len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: cap zero keeps nothing
    push_col(100, 1, 1);
    settle();

    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_MAX_SEL, 32);
    push_col(0, 1, 0);
    push_col(1, 1, 0);
    push_col(32'hFFFFF, 1, 0);
    push_col(32'hFFFFF, 0, 0);
    push_col(5, 1, 0);
    push_col(1, 1, 1);
    settle();

    write_reg(CFG_MAX_SEL, 0);
    push_col(500, 1, 0);
    push_col(32'hFFFFF, 1, 1);
    settle();

    write_reg(CFG_THRESHOLD, 32'hFFFFF);
    write_reg(CFG_MAX_SEL, 63);
    push_col(32'hFFFFF, 1, 0);
    push_col(32'hFFFFF, 1, 1);
    settle();

    // full table: equal count stays out, larger one displaces the tail
    write_reg(CFG_THRESHOLD, 10);
    write_reg(CFG_MAX_SEL, 2);
    push_col(50, 1, 0);
    push_col(40, 1, 0);
    push_col(40, 1, 0);
    push_col(45, 1, 0);
    push_col(60, 1, 1);
    settle();

    // cap lowered mid-matrix
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_MAX_SEL, 4);
    push_col(10, 1, 0);
    push_col(20, 1, 0);
    push_col(30, 1, 0);
    push_col(40, 1, 0);
    settle();
    write_reg(CFG_MAX_SEL, 2);
    push_col(5, 1, 1);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
      recv_idle_pct = (ph == 0) ? 54 : (ph == 1) ? 9 : 0;
      fed = 0;
      if (ph == 1) begin
        // receiver stalls long while several matrices queue up behind it
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_MAX_SEL, 8);
        hold_req <= 1'b1;
        for (int m = 0; m < 3; m++) begin
          feed_matrix(5, 1);
          fed += 5;
        end
        settle();
      end
      if (ph == 2) begin
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_MAX_SEL, 32);
        feed_matrix(36, 1);
        fed += 36;
        settle();
      end
      while (fed < PHASE_ITEMS) begin
        if ($urandom_range(1)) pick_threshold();
        if ($urandom_range(1)) pick_cap();
        len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 8);
        feed_matrix(len, 0);
        fed += len;
        settle();
      end
      settle();
    end

    settle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("dense_column_top_k_select verification clean");
    end else begin
      $display("dense_column_top_k_select verification failed");
    end
    $finish;
  end

endmodule
